// ===== sv/tcgr_pkg.sv =====
// ============================================================================
// tcgr_pkg
// Shared types and constants for the text console glyph renderer.
// ============================================================================
package tcgr_pkg;

    // Request kinds carried on s_tuser
    localparam logic [1:0] MODE_AT_CURSOR = 2'd0;
    localparam logic [1:0] MODE_AT_CELL   = 2'd1;
    localparam logic [1:0] MODE_LOAD_FONT = 2'd2;
    localparam logic [1:0] MODE_NONE      = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] REG_TEXT_ROWS    = 2'd0;
    localparam logic [1:0] REG_TEXT_COLUMNS = 2'd1;
    localparam logic [1:0] REG_PITCH_WORDS  = 2'd2;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 13;

    // Field widths
    localparam int CODE_W   = 8;
    localparam int PAL_W    = 5;
    localparam int COL_W    = 9;
    localparam int ROW_W    = 8;
    localparam int GLINE_W  = 4;
    localparam int GBITS_W  = 8;
    localparam int PITCH_W  = 13;
    localparam int OFFSET_W = 24;
    localparam int PIXEL_W  = 16;

    // Printable range of character codes
    localparam logic [CODE_W-1:0] CODE_FIRST = 8'd32;
    localparam logic [CODE_W-1:0] CODE_LAST  = 8'd127;

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 56;

    typedef logic [PIXEL_W-1:0] rgb565_t;

    // Fixed 18-entry palette; anything past it is black.
    function automatic rgb565_t palette_color(input logic [PAL_W-1:0] idx);
        rgb565_t c;
        case (idx)
            5'd1:    c = 16'hDEFB;
            5'd2:    c = 16'h2966;
            5'd3:    c = 16'hDB6E;
            5'd4:    c = 16'h7EED;
            5'd5:    c = 16'hF7EC;
            5'd6:    c = 16'h4D9E;
            5'd7:    c = 16'hFB3D;
            5'd8:    c = 16'h55B8;
            5'd9:    c = 16'hFFFF;
            5'd10:   c = 16'hAD97;
            5'd11:   c = 16'hDB6E;
            5'd12:   c = 16'h7EED;
            5'd13:   c = 16'hF7EC;
            5'd14:   c = 16'h4D9E;
            5'd15:   c = 16'hFB3D;
            5'd16:   c = 16'h55B8;
            5'd17:   c = 16'hFFFF;
            default: c = 16'h0000;
        endcase
        return c;
    endfunction

endpackage

// ===== sv/text_console_glyph_renderer_top.sv =====
// ============================================================================
// text_console_glyph_renderer_top
// Text console character generator: glyph store, cursor and pixel writer.
// ============================================================================
// Usage:
//   Requests arrive on the s_ stream. s_tuser selects the kind: draw at the
//   cursor, draw at a given cell, or load one glyph row. A font load writes the
//   glyph store in the cycle it is accepted and produces nothing. A draw of a
//   printable code on screen produces 4*GLYPH_HEIGHT transactions on the m_
//   stream (64 at the default), one framebuffer word each: word offset in the
//   low 24 bits of m_tdata, two RGB565 pixels above it; m_tlast marks the
//   final word of the character.
//   Timing: a draw is accepted, then comes the row*pitch multiply, then the
//   first glyph store read, then one word per cycle while the receiver does
//   not stall. The word rate is set by the single output register; the glyph
//   store is read once per glyph line, prefetching the next line while the
//   current one is emitted. Requests that produce nothing (loads, dropped
//   draws) leave the block idle. s_tready is high only between draws; a new
//   request is taken while the last word of the previous character still
//   waits in the output register. When the receiver stalls, the output
//   register holds its word and the draw sequencer waits; nothing is dropped.
//   Reset clears the cursor and the three configuration registers. The glyph
//   store is not cleared; load every glyph before drawing it.
//   The configuration port (cfg_*) is always ready; the user must write it
//   only while idle, which the block itself does not enforce.
// ============================================================================
module text_console_glyph_renderer_top #(
    parameter int GLYPH_HEIGHT = 16,
    parameter int GLYPH_COUNT  = 128
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,

    // Request stream
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // [7:0] char_code, [12:8] fore_index, [17:13] back_index,
    // [26:18] cell_column, [34:27] cell_row, [38:35] glyph_line,
    // [46:39] glyph_bits, [47] zero
    input  logic [tcgr_pkg::S_TDATA_W-1:0]       s_tdata,
    // [1:0] mode
    input  logic [1:0]                           s_tuser,

    // Framebuffer word stream
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // [23:0] word_offset, [55:24] pixel_pair
    output logic [tcgr_pkg::M_TDATA_W-1:0]       m_tdata,
    output logic                                 m_tlast,

    // Configuration write channel
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [tcgr_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [tcgr_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int STORE_DEPTH = GLYPH_COUNT * GLYPH_HEIGHT;
    localparam int AW          = $clog2(STORE_DEPTH);
    localparam int LW          = $clog2(GLYPH_HEIGHT);
    localparam logic [LW-1:0] LINE_LAST = LW'(GLYPH_HEIGHT - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BASE,    // row*pitch multiply, first glyph line read issued
        ST_FETCH,   // first glyph line lands, second read issued
        ST_DRAW     // one word per free output slot
    } state_t;

    // ------------------------------------------------------------------
    // Input field unpacking
    // ------------------------------------------------------------------
    logic [1:0]                       in_mode;
    logic [tcgr_pkg::CODE_W-1:0]      in_code;
    logic [tcgr_pkg::PAL_W-1:0]       in_fore;
    logic [tcgr_pkg::PAL_W-1:0]       in_back;
    logic [tcgr_pkg::COL_W-1:0]       in_col;
    logic [tcgr_pkg::ROW_W-1:0]       in_row;
    logic [tcgr_pkg::GLINE_W-1:0]     in_gline;
    logic [tcgr_pkg::GBITS_W-1:0]     in_gbits;

    assign in_mode  = s_tuser;
    assign in_code  = s_tdata[7:0];
    assign in_fore  = s_tdata[12:8];
    assign in_back  = s_tdata[17:13];
    assign in_col   = s_tdata[26:18];
    assign in_row   = s_tdata[34:27];
    assign in_gline = s_tdata[38:35];
    assign in_gbits = s_tdata[46:39];

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    state_t                           state_reg;
    logic [tcgr_pkg::ROW_W-1:0]       text_rows_reg;
    logic [tcgr_pkg::COL_W-1:0]       text_cols_reg;
    logic [tcgr_pkg::PITCH_W-1:0]     pitch_reg;
    logic [tcgr_pkg::COL_W-1:0]       cursor_col_reg;
    logic [tcgr_pkg::ROW_W-1:0]       cursor_row_reg;

    logic [AW-1:0]                    glyph_base_reg;   // code*GLYPH_HEIGHT
    logic [tcgr_pkg::OFFSET_W-1:0]    row_lines_reg;    // row*GLYPH_HEIGHT
    logic [tcgr_pkg::COL_W-1:0]       col_reg;
    tcgr_pkg::rgb565_t                fore_reg;
    tcgr_pkg::rgb565_t                back_reg;
    logic [tcgr_pkg::OFFSET_W-1:0]    line_base_reg;
    logic [tcgr_pkg::GBITS_W-1:0]     bits_reg;         // shifts left 2 per word
    logic [LW-1:0]                    line_reg;
    logic [1:0]                       word_reg;

    logic                             m_tvalid_reg;
    logic [tcgr_pkg::OFFSET_W-1:0]    m_offset_reg;
    logic [2*tcgr_pkg::PIXEL_W-1:0]   m_pixels_reg;
    logic                             m_tlast_reg;

    // Glyph store
    logic [tcgr_pkg::GBITS_W-1:0]     glyph_mem [STORE_DEPTH];
    logic [tcgr_pkg::GBITS_W-1:0]     glyph_q;
    logic [AW-1:0]                    rd_addr;
    logic [AW-1:0]                    wr_addr;
    logic                             wr_en;

    // ------------------------------------------------------------------
    // Request decode at accept time
    // ------------------------------------------------------------------
    logic                             s_fire;
    logic                             is_draw_mode;
    logic                             printable;
    logic [tcgr_pkg::COL_W-1:0]       pos_col;
    logic [tcgr_pkg::ROW_W-1:0]       pos_row;
    logic                             row_on_screen;
    logic                             col_wraps;
    logic [tcgr_pkg::COL_W-1:0]       draw_col;
    logic [tcgr_pkg::ROW_W:0]         draw_row;
    logic                             draw_on_screen;
    logic                             start_draw;
    logic                             load_ok;

    assign s_tready     = (state_reg == ST_IDLE);
    assign s_fire       = s_tvalid && s_tready;
    assign is_draw_mode = (in_mode == tcgr_pkg::MODE_AT_CURSOR) ||
                          (in_mode == tcgr_pkg::MODE_AT_CELL);
    assign printable    = (in_code >= tcgr_pkg::CODE_FIRST) &&
                          (in_code <= tcgr_pkg::CODE_LAST);
    assign pos_col      = (in_mode == tcgr_pkg::MODE_AT_CURSOR) ? cursor_col_reg : in_col;
    assign pos_row      = (in_mode == tcgr_pkg::MODE_AT_CURSOR) ? cursor_row_reg : in_row;
    assign row_on_screen = pos_row < text_rows_reg;
    // Column past the end wraps to column 0 of the next row
    assign col_wraps    = pos_col >= text_cols_reg;
    assign draw_col     = col_wraps ? '0 : pos_col;
    assign draw_row     = {1'b0, pos_row} + (tcgr_pkg::ROW_W+1)'(col_wraps);
    assign draw_on_screen = draw_row < {1'b0, text_rows_reg};
    assign start_draw   = s_fire && is_draw_mode && printable &&
                          row_on_screen && draw_on_screen;

    // Font load: out-of-range code or line is ignored
    assign load_ok = ({1'b0, in_code} < (tcgr_pkg::CODE_W+1)'(GLYPH_COUNT)) &&
                     ({2'b00, in_gline} < (tcgr_pkg::GLINE_W+2)'(GLYPH_HEIGHT));
    assign wr_en   = s_fire && (in_mode == tcgr_pkg::MODE_LOAD_FONT) && load_ok;
    assign wr_addr = AW'((AW+1)'(in_code) * (AW+1)'(GLYPH_HEIGHT) + (AW+1)'(in_gline));

    // ------------------------------------------------------------------
    // Glyph store read address: line 0 in ST_BASE, then the line after the one being
    // emitted (held at the last), so its data is ready when the line advances.
    // ------------------------------------------------------------------
    logic [LW-1:0] next_line;
    assign next_line = (state_reg == ST_BASE) ? '0 :
                       (line_reg == LINE_LAST) ? line_reg : line_reg + LW'(1);
    assign rd_addr   = glyph_base_reg + AW'(next_line);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            glyph_mem[wr_addr] <= in_gbits;
        end
        glyph_q <= glyph_mem[rd_addr];
    end

    // ------------------------------------------------------------------
    // Word generation
    // ------------------------------------------------------------------
    logic                             out_free;
    logic                             word_last;
    logic [tcgr_pkg::OFFSET_W-1:0]    line_base_next;
    tcgr_pkg::rgb565_t                pix_left;
    tcgr_pkg::rgb565_t                pix_right;

    assign out_free   = !m_tvalid_reg || m_tready;
    assign word_last  = (line_reg == LINE_LAST) && (word_reg == 2'd3);
    assign line_base_next = tcgr_pkg::OFFSET_W'(row_lines_reg * tcgr_pkg::OFFSET_W'(pitch_reg))
                          + tcgr_pkg::OFFSET_W'({col_reg, 2'b00});
    assign pix_left   = bits_reg[7] ? fore_reg : back_reg;
    assign pix_right  = bits_reg[6] ? fore_reg : back_reg;

    // ------------------------------------------------------------------
    // Control, configuration and output register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            text_rows_reg  <= '0;
            text_cols_reg  <= '0;
            pitch_reg      <= '0;
            cursor_col_reg <= '0;
            cursor_row_reg <= '0;
            m_tvalid_reg   <= 1'b0;
            line_reg       <= '0;
            word_reg       <= '0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_addr)
                    tcgr_pkg::REG_TEXT_ROWS:    text_rows_reg <= cfg_data[tcgr_pkg::ROW_W-1:0];
                    tcgr_pkg::REG_TEXT_COLUMNS: text_cols_reg <= cfg_data[tcgr_pkg::COL_W-1:0];
                    tcgr_pkg::REG_PITCH_WORDS:  pitch_reg     <= cfg_data;
                    default: ;
                endcase
            end

            if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    line_reg <= '0;
                    word_reg <= '0;
                    if (s_fire && is_draw_mode && printable && row_on_screen) begin
                        // Cursor keeps the wrap even if the draw is then dropped
                        if (in_mode == tcgr_pkg::MODE_AT_CURSOR && col_wraps) begin
                            cursor_col_reg <= '0;
                            cursor_row_reg <= draw_row[tcgr_pkg::ROW_W-1:0];
                        end
                        if (in_mode == tcgr_pkg::MODE_AT_CURSOR && draw_on_screen) begin
                            cursor_col_reg <= draw_col + tcgr_pkg::COL_W'(1);
                        end
                    end
                    if (start_draw) begin
                        glyph_base_reg <= AW'((AW+1)'(in_code) * (AW+1)'(GLYPH_HEIGHT));
                        row_lines_reg  <= tcgr_pkg::OFFSET_W'(draw_row) *
                                          tcgr_pkg::OFFSET_W'(GLYPH_HEIGHT);
                        col_reg        <= draw_col;
                        fore_reg       <= tcgr_pkg::palette_color(in_fore);
                        back_reg       <= tcgr_pkg::palette_color(in_back);
                        state_reg      <= ST_BASE;
                    end
                end
                ST_BASE: begin
                    line_base_reg <= line_base_next;
                    state_reg     <= ST_FETCH;
                end
                ST_FETCH: begin
                    bits_reg  <= glyph_q;
                    state_reg <= ST_DRAW;
                end
                ST_DRAW: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_offset_reg <= line_base_reg + tcgr_pkg::OFFSET_W'(word_reg);
                        m_pixels_reg <= {pix_right, pix_left};
                        m_tlast_reg  <= word_last;
                        word_reg     <= word_reg + 2'd1;
                        if (word_reg == 2'd3) begin
                            bits_reg      <= glyph_q;
                            line_reg      <= line_reg + LW'(1);
                            line_base_reg <= line_base_reg + tcgr_pkg::OFFSET_W'(pitch_reg);
                        end else begin
                            bits_reg <= {bits_reg[tcgr_pkg::GBITS_W-3:0], 2'b00};
                        end
                        if (word_last) begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {m_pixels_reg, m_offset_reg};
    assign m_tlast   = m_tlast_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_last_ends_draw: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DRAW && out_free && word_last) |=> (state_reg == ST_IDLE))
        else $error("draw did not finish after its last word");

    a_fetch_to_draw: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FETCH) |=> (state_reg == ST_DRAW && line_reg == '0 &&
                                     word_reg == 2'd0))
        else $error("draw did not start at line 0 word 0");

    a_cursor_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_fire |=> ($stable(cursor_col_reg) && $stable(cursor_row_reg)))
        else $error("cursor moved without a request");

    a_no_emit_outside_draw: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_tvalid_reg && state_reg != ST_DRAW) |=> !m_tvalid_reg)
        else $error("word emitted outside a draw");

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Self-checking bench for the text console glyph renderer. Glyph rows are
// loaded, the screen geometry is set through the config port, and draws go in
// at the cursor and at given cells. A predictor in the bench computes every
// framebuffer word, and each word out of the block is compared against it.
// Both stream sides idle and stall at random, and one long receiver hold-off
// backs the block up into its input.
// ============================================================================
module testbench;
    import tcgr_pkg::*;

    localparam int LINES_PER_GLYPH = 16;
    localparam int GLYPH_SLOTS     = 128;
    localparam int WORDS_PER_LINE  = 4;
    localparam int SETTLE_CYCLES   = 8;
    localparam int HOLD_CYCLES     = 400;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int REPORT_LIMIT    = 10;
    localparam int PALETTE_SIZE    = 18;

    // entry 0 in the low 16 bits
    localparam logic [PALETTE_SIZE*PIXEL_W-1:0] COLOR_TABLE = {
        16'hFFFF, 16'h55B8, 16'hFB3D, 16'h4D9E, 16'hF7EC, 16'h7EED,
        16'hDB6E, 16'hAD97, 16'hFFFF, 16'h55B8, 16'hFB3D, 16'h4D9E,
        16'hF7EC, 16'h7EED, 16'hDB6E, 16'h2966, 16'hDEFB, 16'h0000
    };

    typedef struct packed {
        logic [1:0]         mode;
        logic [CODE_W-1:0]  char_code;
        logic [PAL_W-1:0]   fore_index;
        logic [PAL_W-1:0]   back_index;
        logic [COL_W-1:0]   cell_column;
        logic [ROW_W-1:0]   cell_row;
        logic [GLINE_W-1:0] glyph_line;
        logic [GBITS_W-1:0] glyph_bits;
    } glyph_req_t;

    typedef struct packed {
        logic [OFFSET_W-1:0]  word_offset;
        logic [2*PIXEL_W-1:0] pixel_pair;
        logic                 last_word;
    } fb_word_t;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic [1:0]            s_tuser   = MODE_AT_CURSOR;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_ADDR_W-1:0] cfg_addr  = REG_TEXT_ROWS;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Predicted block state
    logic [ROW_W-1:0]   scr_rows   = '0;
    logic [COL_W-1:0]   scr_cols   = '0;
    logic [PITCH_W-1:0] scr_pitch  = '0;
    logic [COL_W-1:0]   cursor_col = '0;
    logic [ROW_W-1:0]   cursor_row = '0;
    logic [GBITS_W-1:0] glyph_rows [GLYPH_SLOTS*LINES_PER_GLYPH];
    logic [15:0]        glyph_filled [GLYPH_SLOTS];
    logic [CODE_W-1:0]  drawable_codes [$];   // printable codes with every row loaded
    fb_word_t           pending_words [$];

    int tx_idle_pct   = 0;
    int rx_stall_pct  = 0;
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;
    int mismatches    = 0;
    int quiet_cycles  = 0;

    text_console_glyph_renderer_top u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic logic [PIXEL_W-1:0] palette_rgb(input logic [PAL_W-1:0] idx);
        return (idx < PALETTE_SIZE) ? COLOR_TABLE[idx*PIXEL_W +: PIXEL_W] : '0;
    endfunction

    // Updates the state for one accepted request and queues the words it draws.
    task automatic render_request(input glyph_req_t r);
        logic [COL_W-1:0]   col;
        logic [ROW_W:0]     row;
        logic [GBITS_W-1:0] bits;
        logic [PIXEL_W-1:0] fg, bg, pl, pr;
        logic [63:0]        base, addr;
        logic               was_full;
        fb_word_t           w;
        int                 slot, line, k;
        if (r.mode == MODE_LOAD_FONT) begin
            if (r.char_code < GLYPH_SLOTS) begin
                slot = r.char_code;
                was_full = &glyph_filled[slot];
                glyph_rows[slot*LINES_PER_GLYPH + r.glyph_line] = r.glyph_bits;
                glyph_filled[slot][r.glyph_line] = 1'b1;
                if (!was_full && (&glyph_filled[slot]) && r.char_code >= CODE_FIRST)
                    drawable_codes.push_back(r.char_code);
            end
            return;
        end
        if (r.mode == MODE_NONE || r.char_code < CODE_FIRST || r.char_code > CODE_LAST)
            return;
        if (r.mode == MODE_AT_CURSOR) begin
            col = cursor_col;
            row = {1'b0, cursor_row};
        end else begin
            col = r.cell_column;
            row = {1'b0, r.cell_row};
        end
        if (row >= scr_rows)
            return;
        // column past the edge wraps to the start of the next row
        if (col >= scr_cols) begin
            col = '0;
            row = row + 1'b1;
            if (r.mode == MODE_AT_CURSOR) begin
                cursor_col = '0;
                cursor_row = row[ROW_W-1:0];
            end
        end
        if (row >= scr_rows)
            return;
        fg = palette_rgb(r.fore_index);
        bg = palette_rgb(r.back_index);
        slot = r.char_code;
        for (line = 0; line < LINES_PER_GLYPH; line++) begin
            bits = glyph_rows[slot*LINES_PER_GLYPH + line];
            base = row;
            base = (base*LINES_PER_GLYPH + line) * scr_pitch + col*WORDS_PER_LINE;
            for (k = 0; k < WORDS_PER_LINE; k++) begin
                pl = bits[7-2*k] ? fg : bg;
                pr = bits[6-2*k] ? fg : bg;
                addr = base + k;
                w.word_offset = addr[OFFSET_W-1:0];
                w.pixel_pair  = {pr, pl};
                w.last_word   = (line == LINES_PER_GLYPH-1) && (k == WORDS_PER_LINE-1);
                pending_words.push_back(w);
            end
        end
        if (r.mode == MODE_AT_CURSOR)
            cursor_col = col + 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------
    // Leaves s_tvalid high after the transaction; the next call or a drain
    // decides whether it drops.
    task automatic send_request(input glyph_req_t r);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= r.mode;
        s_tdata  <= {1'b0, r.glyph_bits, r.glyph_line, r.cell_row, r.cell_column,
                     r.back_index, r.fore_index, r.char_code};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        render_request(r);
    endtask

    function automatic glyph_req_t make_req(
        input logic [1:0] mode, input logic [CODE_W-1:0] code,
        input logic [PAL_W-1:0] fore, input logic [PAL_W-1:0] back,
        input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row,
        input logic [GLINE_W-1:0] line, input logic [GBITS_W-1:0] bits);
        glyph_req_t r;
        r.mode        = mode;
        r.char_code   = code;
        r.fore_index  = fore;
        r.back_index  = back;
        r.cell_column = col;
        r.cell_row    = row;
        r.glyph_line  = line;
        r.glyph_bits  = bits;
        return r;
    endfunction

    // All sixteen rows of one glyph; first row blank, last row solid.
    task automatic load_glyph(input logic [CODE_W-1:0] code);
        logic [GBITS_W-1:0] bits;
        int line;
        for (line = 0; line < LINES_PER_GLYPH; line++) begin
            bits = (line == 0) ? 8'h00 : (line == LINES_PER_GLYPH-1) ? 8'hFF : $urandom_range(255);
            send_request(make_req(MODE_LOAD_FONT, code, $urandom_range(31), $urandom_range(31),
                                  $urandom_range(511), $urandom_range(255), line, bits));
        end
    endtask

    function automatic logic [CODE_W-1:0] pick_drawable();
        return drawable_codes[$urandom_range(drawable_codes.size()-1)];
    endfunction

    function automatic glyph_req_t random_request();
        glyph_req_t r;
        int pick;
        r.fore_index  = ($urandom_range(4) == 0) ? $urandom_range(31) : $urandom_range(17);
        r.back_index  = ($urandom_range(4) == 0) ? $urandom_range(31) : $urandom_range(17);
        r.cell_column = ($urandom_range(4) == 0) ? $urandom_range(511) : $urandom_range(scr_cols);
        r.cell_row    = ($urandom_range(4) == 0) ? $urandom_range(255) : $urandom_range(scr_rows);
        r.glyph_line  = $urandom_range(15);
        r.glyph_bits  = $urandom_range(255);
        pick = $urandom_range(99);
        if (pick < 60) begin
            r.mode      = (pick < 30) ? MODE_AT_CURSOR : MODE_AT_CELL;
            r.char_code = pick_drawable();
        end else if (pick < 72) begin
            r.mode      = pick[0] ? MODE_AT_CURSOR : MODE_AT_CELL;
            r.char_code = $urandom_range(1) ? $urandom_range(31) : $urandom_range(255, 128);
        end else if (pick < 94) begin
            r.mode      = MODE_LOAD_FONT;
            r.char_code = $urandom_range(255);
        end else begin
            r.mode      = MODE_NONE;
            r.char_code = $urandom_range(255);
        end
        return r;
    endfunction

    // Stops offering requests and waits until the block has gone quiet.
    task automatic drain_pipeline();
        s_tvalid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic put_register(input logic [CFG_ADDR_W-1:0] addr,
                                input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_addr  <= addr;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        case (addr)
            REG_TEXT_ROWS:    scr_rows  = data[ROW_W-1:0];
            REG_TEXT_COLUMNS: scr_cols  = data[COL_W-1:0];
            REG_PITCH_WORDS:  scr_pitch = data[PITCH_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_screen(input int rows, input int cols, input int pitch);
        drain_pipeline();
        put_register(REG_TEXT_ROWS, rows);
        put_register(REG_TEXT_COLUMNS, cols);
        put_register(REG_PITCH_WORDS, pitch);
        cfg_valid <= 1'b0;
    endtask

    // Screen tall enough that the cursor still has rows left below it.
    function automatic int rows_below_cursor();
        int rows;
        rows = cursor_row + $urandom_range(6, 2);
        return (rows > 128) ? 128 : rows;
    endfunction

    // ------------------------------------------------------------------------
    // Result side: check every word, stall at random, honor hold-off requests
    // ------------------------------------------------------------------------
    task automatic note_mismatch(input string what);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("mismatch: %s", what);
    endtask

    task automatic check_word();
        fb_word_t got, want;
        got.word_offset = m_tdata[OFFSET_W-1:0];
        got.pixel_pair  = m_tdata[OFFSET_W +: 2*PIXEL_W];
        got.last_word   = m_tlast;
        if (pending_words.size() == 0) begin
            note_mismatch($sformatf("unexpected word: offset %h pixels %h last %b",
                                    got.word_offset, got.pixel_pair, got.last_word));
        end else begin
            want = pending_words.pop_front();
            if (got.word_offset !== want.word_offset)
                note_mismatch($sformatf("word_offset expected %h actual %h",
                                        want.word_offset, got.word_offset));
            if (got.pixel_pair !== want.pixel_pair)
                note_mismatch($sformatf("pixel_pair at %h expected %h actual %h",
                                        want.word_offset, want.pixel_pair, got.pixel_pair));
            if (got.last_word !== want.last_word)
                note_mismatch($sformatf("last_word at %h expected %b actual %b",
                                        want.word_offset, want.last_word, got.last_word));
        end
    endtask

    always @(posedge aclk) begin
        if (m_tvalid && m_tready)
            check_word();
        if (hold_requests != hold_served) begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Watchdog: too long without any transaction on any channel
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL text_console_glyph_renderer_top");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Glyphs for both ends of the printable range, a load past the glyph
    // count, a load into an unprintable slot and the unused request kind.
    task automatic test_font_load();
        load_glyph(CODE_FIRST);
        load_glyph(CODE_LAST);
        send_request(make_req(MODE_LOAD_FONT, 8'd200, 5'd0, 5'd0, 9'd0, 8'd0, 4'd5, 8'hA5));
        send_request(make_req(MODE_LOAD_FONT, 8'd0, 5'd31, 5'd31, 9'd511, 8'd255,
                              4'd15, 8'h3C));
        send_request(make_req(MODE_NONE, 8'd65, 5'd17, 5'd3, 9'd10, 8'd1, 4'd2, 8'hFF));
    endtask

    // No rows on screen: every draw drops, cursor stays put.
    task automatic test_empty_screen();
        set_screen(0, 40, 64);
        send_request(make_req(MODE_AT_CURSOR, CODE_FIRST, 5'd1, 5'd2, 9'd0, 8'd0, 4'd0, 8'd0));
        send_request(make_req(MODE_AT_CELL, CODE_LAST, 5'd1, 5'd2, 9'd0, 8'd0, 4'd0, 8'd0));
    endtask

    // Zero columns: every cell wraps to column 0 of the next row, drawn only if that row exists.
    task automatic test_zero_columns();
        set_screen(2, 0, 0);
        send_request(make_req(MODE_AT_CURSOR, CODE_FIRST, 5'd1, 5'd2, 9'd0, 8'd0, 4'd0, 8'd0));
        send_request(make_req(MODE_AT_CURSOR, CODE_LAST, 5'd3, 5'd4, 9'd0, 8'd0, 4'd0, 8'd0));
        send_request(make_req(MODE_AT_CELL, CODE_LAST, 5'd5, 5'd6, 9'd5, 8'd0, 4'd0, 8'd0));
        send_request(make_req(MODE_AT_CELL, CODE_FIRST, 5'd7, 5'd8, 9'd0, 8'd1, 4'd0, 8'd0));
    endtask

    // A large geometry: corner cells, wrap off the bottom, out-of-range
    // palette indices and codes just outside the printable range.
    task automatic test_full_screen();
        set_screen(128, 256, 4096);
        send_request(make_req(MODE_AT_CELL, CODE_LAST, 5'd17, 5'd0, 9'd255, 8'd127, 4'd0, 8'd0));
        send_request(make_req(MODE_AT_CELL, CODE_LAST, 5'd9, 5'd10, 9'd256, 8'd127, 4'd0, 8'd0));
        send_request(make_req(MODE_AT_CELL, CODE_FIRST, 5'd9, 5'd10, 9'd511, 8'd255, 4'd0, 8'd0));
        send_request(make_req(MODE_AT_CELL, CODE_FIRST, 5'd31, 5'd18, 9'd0, 8'd0, 4'd0, 8'd0));
        send_request(make_req(MODE_AT_CELL, 8'd31, 5'd1, 5'd2, 9'd0, 8'd0, 4'd0, 8'd0));
        send_request(make_req(MODE_AT_CELL, 8'd128, 5'd1, 5'd2, 9'd0, 8'd0, 4'd0, 8'd0));
        send_request(make_req(MODE_AT_CURSOR, 8'd255, 5'd1, 5'd2, 9'd0, 8'd0, 4'd0, 8'd0));
        send_request(make_req(MODE_AT_CURSOR, 8'd0, 5'd1, 5'd2, 9'd0, 8'd0, 4'd0, 8'd0));
        send_request(make_req(MODE_AT_CURSOR, CODE_LAST, 5'd11, 5'd16, 9'd0, 8'd0, 4'd0, 8'd0));
    endtask

    // Cursor runs off the last row (kept wrapped, not advanced), then the
    // screen grows and the cursor wraps onto a row that exists.
    task automatic test_cursor_wrap();
        int i;
        set_screen(3, 2, 5);
        for (i = 0; i < 3; i++)
            send_request(make_req(MODE_AT_CURSOR, CODE_FIRST + i, 5'd12, 5'd13,
                                  9'd0, 8'd0, 4'd0, 8'd0));
        set_screen(5, 2, 5);
        for (i = 0; i < 3; i++)
            send_request(make_req(MODE_AT_CURSOR, CODE_LAST, 5'd14, 5'd15,
                                  9'd0, 8'd0, 4'd0, 8'd0));
    endtask

    // Receiver holds off for a long stretch while draws keep coming, so the
    // block backs up and stops taking requests.
    task automatic test_output_backpressure();
        int i;
        set_screen(rows_below_cursor(), 16, 300);
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        hold_requests++;
        for (i = 0; i < 8; i++)
            send_request(make_req(MODE_AT_CELL, pick_drawable(), $urandom_range(17),
                                  $urandom_range(17), $urandom_range(15),
                                  $urandom_range(scr_rows-1), 4'd0, 8'd0));
    endtask

    // Mostly draws of loaded glyphs, with loads, dropped codes and noise mixed
    // in; now and then a whole new glyph is loaded.
    task automatic test_random_traffic(input int count, input int tx_pct, input int rx_pct);
        int i;
        set_screen(rows_below_cursor(), $urandom_range(12, 1), $urandom_range(4096));
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        for (i = 0; i < count; i++) begin
            if ($urandom_range(24) == 0)
                load_glyph($urandom_range(127, 32));
            else
                send_request(random_request());
        end
    endtask

    initial begin
        foreach (glyph_filled[i])
            glyph_filled[i] = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_font_load();
        test_empty_screen();
        test_zero_columns();
        test_full_screen();
        test_cursor_wrap();
        test_output_backpressure();
        test_random_traffic(45, 0, 0);
        test_random_traffic(45, 46, 0);
        test_random_traffic(45, 0, 46);
        test_random_traffic(45, 7, 7);

        drain_pipeline();
        repeat (20) @(posedge aclk);
        if (mismatches == 0 && pending_words.size() == 0)
            $display("PASS text_console_glyph_renderer_top");
        else
            $display("FAIL text_console_glyph_renderer_top");
        $finish;
    end

endmodule

// ===== text_console_glyph_renderer_top.f =====
sv/tcgr_pkg.sv
sv/text_console_glyph_renderer_top.sv
dv/testbench.sv
